FILE: hdl/bsed_pkg.sv
// shared types, character codes and helpers for the backslash escape decoder
`timescale 1ns / 1ps
package bsed_pkg;

  localparam int unsigned BSED_QUEUE_DEPTH = 4;
  localparam int unsigned BSED_MAX_BYTES   = 3;

  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_X      = 8'h78;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_TAB    = 8'h09;

  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_HEX0 = 4'b0100,
    MODE_HEX1 = 4'b1000
  } mode_e;

  // one decoded group: up to three bytes from a single input transaction
  typedef struct packed {
    logic [BSED_MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                     cnt;
    logic                           last;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_of(input logic [7:0] ch);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      h.val = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      h.val = 4'(ch[3:0] + 4'd9);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hdl/bsed_front.sv
// front end: accepts raw bytes, tracks escape state and forms decoded groups
`timescale 1ns / 1ps
module bsed_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            push_o,
  output bsed_pkg::entry_t push_entry_o
);
  import bsed_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  entry_t     ent;
  hex_t       hex_in, hex_held;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hex_in     = hex_of(in_byte_i);
  assign hex_held   = hex_of(held_q);

  always_comb begin
    ent    = '0;
    mode_d = MODE_TEXT;
    held_d = held_q;
    unique case (mode_q)
      MODE_TEXT: begin
        if (in_byte_i == CHR_BSLASH && !in_last_i) begin
          mode_d = MODE_ESC;
        end else begin
          ent.bytes[0] = in_byte_i;
          ent.cnt      = 2'd1;
        end
      end
      MODE_ESC: begin
        ent.cnt = 2'd1;
        case (in_byte_i)
          CHR_N: ent.bytes[0] = CHR_LF;
          CHR_R: ent.bytes[0] = CHR_CR;
          CHR_T: ent.bytes[0] = CHR_TAB;
          CHR_X: begin
            if (in_last_i) begin
              ent.bytes[0] = CHR_X;
            end else begin
              ent.cnt = 2'd0;
              mode_d  = MODE_HEX0;
            end
          end
          default: ent.bytes[0] = in_byte_i;
        endcase
      end
      MODE_HEX0: begin
        if (hex_in.ok && !in_last_i) begin
          held_d = in_byte_i;
          mode_d = MODE_HEX1;
        end else begin
          // bad or cut-off escape: literal x, then byte as text or an escape
          ent.bytes[0] = CHR_X;
          if (in_byte_i == CHR_BSLASH && !in_last_i) begin
            ent.cnt = 2'd1;
            mode_d  = MODE_ESC;
          end else begin
            ent.bytes[1] = in_byte_i;
            ent.cnt      = 2'd2;
          end
        end
      end
      default: begin
        held_d = '0;
        if (hex_in.ok) begin
          ent.bytes[0] = {hex_held.val, hex_in.val};
          ent.cnt      = 2'd1;
        end else begin
          ent.bytes[0] = CHR_X;
          ent.bytes[1] = held_q;
          if (in_byte_i == CHR_BSLASH && !in_last_i) begin
            ent.cnt = 2'd2;
            mode_d  = MODE_ESC;
          end else begin
            ent.bytes[2] = in_byte_i;
            ent.cnt      = 2'd3;
          end
        end
      end
    endcase
    ent.last = in_last_i;
    if (in_last_i) begin
      mode_d = MODE_TEXT;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  assign push_o       = accept && (ent.cnt != 2'd0);
  assign push_entry_o = ent;

endmodule

FILE: hdl/bsed_queue.sv
// small queue of decoded groups between front end and back end
`timescale 1ns / 1ps
module bsed_queue #(
  parameter int unsigned Depth = bsed_pkg::BSED_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bsed_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output bsed_pkg::entry_t head_o
);
  import bsed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule

FILE: hdl/bsed_back.sv
// back end: walks each decoded group byte by byte into the output register
`timescale 1ns / 1ps
module bsed_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  bsed_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  input  logic             out_ready_i
);
  import bsed_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load, final_byte;

  assign load       = !q_empty_i && (!out_valid_q || out_ready_i);
  assign final_byte = (idx_q == 2'(head_i.cnt - 2'd1));
  assign pop_o      = load && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= final_byte ? 2'd0 : 2'(idx_q + 2'd1);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= head_i.bytes[idx_q];
      out_last_q <= final_byte && head_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: hdl/backslash_escape_decoder.sv
// Backslash escape decoder top level. One raw byte is taken per cycle; each
// transaction yields zero to three decoded bytes (three only for a broken \x
// escape after a valid first digit). The front end decides a whole group in the
// cycle it accepts the byte, and the back end sends it out one byte per cycle
// while not stalled, from a single output register. Sustained rate is one input
// per cycle as long as each transaction yields at most one byte and the output
// does not stall; multi-byte groups hold the output until all their bytes are
// sent, and the group queue (QueueDepth entries) absorbs them until it fills and
// s_axis_tready_o drops.
`timescale 1ns / 1ps
module backslash_escape_decoder #(
  parameter int unsigned QueueDepth = bsed_pkg::BSED_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // out_last
);
  import bsed_pkg::*;

  logic   q_full, q_empty, push, pop;
  entry_t push_entry, head;

  bsed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bsed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  bsed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

FILE: hdl/bsed_checker.sv
// port-level checks for the backslash escape decoder, bound to the top level
`timescale 1ns / 1ps
module bsed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // a stalled output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  // a waiting input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tlast_i))
    else $error("input changed while waiting");

  // nothing comes out right after reset
  a_out_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

  // the queue starts empty, so input is taken right after reset
  a_ready_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_o)
    else $error("input not ready right after reset");

  // just after reset, if no input transaction was taken before, no output is valid
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) ##1 !($past(s_axis_tvalid_i && s_axis_tready_o)) |-> !m_axis_tvalid_o)
    else $error("output without input");

endmodule

bind backslash_escape_decoder bsed_checker u_bsed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
